// File: src/hmrc_pkg.sv
// ----------------------------------------------------------------------------
// hmrc_pkg: shared types and constants of the homing motor run controller
// Item and result layouts, configuration register map and reset values.
// ----------------------------------------------------------------------------
package hmrc_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned DEB_W      = 4;

    // configuration register map
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANKING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD    = 3'd5;

    // reset values of the configuration registers
    localparam logic [DEB_W-1:0]      RST_DEBOUNCE = 4'd3;
    localparam logic [CFG_DATA_W-1:0] RST_BLANKING = 16'd250;
    localparam logic [CFG_DATA_W-1:0] RST_OVERRUN  = 16'd50;
    localparam logic [CFG_DATA_W-1:0] RST_SAFETY   = 16'd1500;
    localparam logic [CFG_DATA_W-1:0] RST_LOCKOUT  = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_GUARD    = 16'd50;

    typedef enum logic [1:0] {
        REQ_NONE         = 2'd0,
        REQ_ACCEPTED     = 2'd1,
        REQ_REFUSED_RUN  = 2'd2,
        REQ_REFUSED_LOCK = 2'd3
    } t_req_status;

    typedef struct packed {
        logic hall_raw;
        logic run_request;
        logic button_edge;
    } t_item;

    typedef struct packed {
        logic        motor_on;
        logic        run_done;
        logic        run_jammed;
        t_req_status request_status;
        logic        hall_level;
    } t_result;

    typedef struct packed {
        logic [DEB_W-1:0]      debounce_samples;
        logic [CFG_DATA_W-1:0] blanking_ticks;
        logic [CFG_DATA_W-1:0] overrun_ticks;
        logic [CFG_DATA_W-1:0] safety_ticks;
        logic [CFG_DATA_W-1:0] lockout_ticks;
        logic [CFG_DATA_W-1:0] button_guard_ticks;
    } t_cfg;

endpackage

// File: src/hmrc_stream_if.sv
// ----------------------------------------------------------------------------
// hmrc_stream_if: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface hmrc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/hmrc_cfg.sv
// ----------------------------------------------------------------------------
// hmrc_cfg: configuration register file
// Decodes the write port into the six timing registers.
// ----------------------------------------------------------------------------
module hmrc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hmrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hmrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output hmrc_pkg::t_cfg                     o_cfg
);

    hmrc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_samples   <= hmrc_pkg::RST_DEBOUNCE;
            r_cfg.blanking_ticks     <= hmrc_pkg::RST_BLANKING;
            r_cfg.overrun_ticks      <= hmrc_pkg::RST_OVERRUN;
            r_cfg.safety_ticks       <= hmrc_pkg::RST_SAFETY;
            r_cfg.lockout_ticks      <= hmrc_pkg::RST_LOCKOUT;
            r_cfg.button_guard_ticks <= hmrc_pkg::RST_GUARD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hmrc_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_samples <= i_cfg_data[hmrc_pkg::DEB_W-1:0];
                end
                hmrc_pkg::CFG_BLANKING: r_cfg.blanking_ticks     <= i_cfg_data;
                hmrc_pkg::CFG_OVERRUN:  r_cfg.overrun_ticks      <= i_cfg_data;
                hmrc_pkg::CFG_SAFETY:   r_cfg.safety_ticks       <= i_cfg_data;
                hmrc_pkg::CFG_LOCKOUT:  r_cfg.lockout_ticks      <= i_cfg_data;
                hmrc_pkg::CFG_GUARD:    r_cfg.button_guard_ticks <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/hmrc_core.sv
// ----------------------------------------------------------------------------
// hmrc_core: per-tick run controller
// Button guard, lockout, request decision, hall debounce, blanking, overrun
// and safety timeout; all state and the result register update on i_en.
// ----------------------------------------------------------------------------
module hmrc_core #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  hmrc_pkg::t_item   i_item,
    input  hmrc_pkg::t_cfg    i_cfg,
    output hmrc_pkg::t_result o_result
);

    localparam int unsigned WW = (TIME_BITS > hmrc_pkg::CFG_DATA_W) ?
                                 TIME_BITS : hmrc_pkg::CFG_DATA_W;
    localparam logic [TIME_BITS-1:0] TMAX   = '1;
    localparam logic [WW-1:0]        TMAX_W = WW'(TMAX);
    localparam logic [TIME_BITS-1:0] T_ONE  = TIME_BITS'(1);
    localparam logic [hmrc_pkg::DEB_W-1:0] CC_MAX = '1;
    localparam logic [hmrc_pkg::DEB_W-1:0] CC_ONE = {{(hmrc_pkg::DEB_W-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RUN     = 2'd1,
        PH_OVERRUN = 2'd2
    } t_phase;

    // register values beyond the counter range saturate to its ceiling
    function automatic logic [TIME_BITS-1:0] clamp_t(
        input logic [hmrc_pkg::CFG_DATA_W-1:0] v
    );
        logic [WW-1:0] w;
        begin
            w = WW'(v);
            clamp_t = (w > TMAX_W) ? TMAX : TIME_BITS'(w);
        end
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        sat_inc = (v == TMAX) ? TMAX : v + T_ONE;
    endfunction

    t_phase                     r_phase, n_phase;
    logic [TIME_BITS-1:0]       r_run_elapsed, n_run_elapsed;
    logic [TIME_BITS-1:0]       r_overrun_left, n_overrun_left;
    logic [TIME_BITS-1:0]       r_lockout_left, n_lockout_left;
    logic [TIME_BITS-1:0]       r_since_button, n_since_button;
    logic                       r_deb_hall, n_deb_hall;
    logic [hmrc_pkg::DEB_W-1:0] r_change_count, n_change_count;
    logic                       r_mag_cleared, n_mag_cleared;
    hmrc_pkg::t_result          r_result, n_result;

    logic [TIME_BITS-1:0] w_blanking, w_overrun, w_safety, w_lockout, w_guard;

    assign w_blanking = clamp_t(i_cfg.blanking_ticks);
    assign w_overrun  = clamp_t(i_cfg.overrun_ticks);
    assign w_safety   = clamp_t(i_cfg.safety_ticks);
    assign w_lockout  = clamp_t(i_cfg.lockout_ticks);
    assign w_guard    = clamp_t(i_cfg.button_guard_ticks);

    always_comb begin
        logic                 req;
        logic                 stop;
        logic                 done;
        logic                 jam;
        logic [TIME_BITS-1:0] el;
        hmrc_pkg::t_req_status status;

        n_phase        = r_phase;
        n_run_elapsed  = r_run_elapsed;
        n_overrun_left = r_overrun_left;
        n_lockout_left = r_lockout_left;
        n_deb_hall     = r_deb_hall;
        n_change_count = r_change_count;
        n_mag_cleared  = r_mag_cleared;
        req            = i_item.run_request;
        stop           = 1'b0;
        done           = 1'b0;
        jam            = 1'b0;
        status         = hmrc_pkg::REQ_NONE;
        el             = '0;

        // button guard
        if (i_item.button_edge && (r_since_button >= w_guard || r_since_button == TMAX)) begin
            req            = 1'b1;
            n_since_button = T_ONE;
        end else begin
            n_since_button = sat_inc(r_since_button);
        end

        if (r_phase == PH_IDLE && r_lockout_left != '0) begin
            n_lockout_left = r_lockout_left - T_ONE;
        end

        if (req) begin
            if (r_phase != PH_IDLE) begin
                status = hmrc_pkg::REQ_REFUSED_RUN;
            end else if (n_lockout_left != '0) begin
                status = hmrc_pkg::REQ_REFUSED_LOCK;
            end else begin
                status         = hmrc_pkg::REQ_ACCEPTED;
                n_phase        = PH_RUN;
                n_run_elapsed  = '0;
                n_deb_hall     = i_item.hall_raw;
                n_change_count = '0;
                n_mag_cleared  = !i_item.hall_raw;
            end
        end

        case (n_phase)
            PH_RUN: begin
                el = n_run_elapsed;
                if (el > w_safety || el == TMAX) begin
                    jam  = 1'b1;
                    stop = 1'b1;
                end else begin
                    if (i_item.hall_raw == n_deb_hall) begin
                        n_change_count = '0;
                    end else begin
                        if (n_change_count != CC_MAX) begin
                            n_change_count = n_change_count + CC_ONE;
                        end
                        if (n_change_count >= i_cfg.debounce_samples) begin
                            n_deb_hall     = i_item.hall_raw;
                            n_change_count = '0;
                        end
                    end
                    if (!n_deb_hall) begin
                        n_mag_cleared = 1'b1;
                    end else if (el >= w_blanking && n_mag_cleared) begin
                        // home return after a clear: overrun, or stop at once
                        if (w_overrun == '0) begin
                            done = 1'b1;
                            stop = 1'b1;
                        end else begin
                            n_phase        = PH_OVERRUN;
                            n_overrun_left = w_overrun;
                        end
                    end
                    n_run_elapsed = sat_inc(el);
                end
            end
            PH_OVERRUN: begin
                if (n_overrun_left != '0) begin
                    n_overrun_left = n_overrun_left - T_ONE;
                end
                if (n_overrun_left == '0) begin
                    done = 1'b1;
                    stop = 1'b1;
                end
            end
            default: ;
        endcase

        if (stop) begin
            n_phase        = PH_IDLE;
            n_overrun_left = '0;
            n_lockout_left = w_lockout;
        end

        n_result.motor_on       = (n_phase != PH_IDLE);
        n_result.run_done       = done;
        n_result.run_jammed     = jam;
        n_result.request_status = status;
        n_result.hall_level     = n_deb_hall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_run_elapsed  <= '0;
            r_overrun_left <= '0;
            r_lockout_left <= '0;
            r_since_button <= '0;
            r_deb_hall     <= 1'b0;
            r_change_count <= '0;
            r_mag_cleared  <= 1'b0;
            r_result       <= '0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_run_elapsed  <= n_run_elapsed;
            r_overrun_left <= n_overrun_left;
            r_lockout_left <= n_lockout_left;
            r_since_button <= n_since_button;
            r_deb_hall     <= n_deb_hall;
            r_change_count <= n_change_count;
            r_mag_cleared  <= n_mag_cleared;
            r_result       <= n_result;
        end
    end

    assign o_result = r_result;

    // a run never ends by both causes in one tick
    a_end_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_result.run_done && r_result.run_jammed))
        else $error("run_done and run_jammed together");

    // an end pulse always leaves the motor off
    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_result.run_done || r_result.run_jammed) |-> !r_result.motor_on)
        else $error("end pulse with motor still on");

    // an accepted request always leaves the motor running
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_result.request_status == hmrc_pkg::REQ_ACCEPTED) |-> r_result.motor_on)
        else $error("accepted request without motor on");

    // result motor level follows the phase register
    a_motor_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_en) |-> (r_result.motor_on == (r_phase != PH_IDLE)))
        else $error("motor_on disagrees with phase");

    // overrun counter is cleared whenever idle
    a_idle_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_overrun_left == '0))
        else $error("overrun count left over while idle");

endmodule

// File: src/homing_motor_run_controller.sv
// ----------------------------------------------------------------------------
// homing_motor_run_controller: one-millisecond-tick motor homing controller
// Input register, per-tick control core and result register.
// ----------------------------------------------------------------------------
//  channel     dir  handshake        payload
//  i_tick      in   valid/ready      hall_raw, run_request, button_edge
//  o_result    out  valid/ready      motor_on, run_done, run_jammed,
//                                    request_status, hall_level
//  i_cfg_*     in   write enable     register index, 16-bit data
//
//  One tick transaction per clock unless the result stalls; a taken tick
//  waits in the input register until the core takes it and offers a result.
//  Reset is synchronous; the block takes ticks in the first cycle after it.
//  A stalled result holds the input register; a new tick is still taken
//  while the result register moves on in the same cycle.
// ----------------------------------------------------------------------------
module homing_motor_run_controller #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hmrc_stream_if.sink                     i_tick,
    hmrc_stream_if.source                   o_result,
    input  logic                            i_cfg_we,
    input  logic [hmrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hmrc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    hmrc_pkg::t_item   r_in_item;
    logic              r_out_valid;
    logic              w_adv;
    hmrc_pkg::t_cfg    w_cfg;
    hmrc_pkg::t_result w_result;

    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tick.ready) begin
                r_in_valid <= i_tick.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_item <= i_tick.data;
        end
    end

    hmrc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    hmrc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_result.valid = r_out_valid;
    assign o_result.data  = w_result;

    // a held tick stays held until the core takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("pending tick dropped");

    // a core update always produces a result transaction
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("tick processed without a result");

endmodule

// File: test/hmrc_run_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hmrc_run_checker: scoreboard for the homing motor run controller
// Mirrors the register writes, predicts the result of every accepted tick
// and compares each accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module hmrc_run_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick_valid,
    input  logic                            i_tick_ready,
    input  hmrc_pkg::t_item                 i_tick_data,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  hmrc_pkg::t_result               i_res_data,
    input  logic                            i_cfg_we,
    input  logic [hmrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hmrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding,
    output int                              o_checked,
    output int                              o_homed,
    output int                              o_jammed
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_OVERRUN
    } t_phase;

    localparam logic [15:0] T_CEIL      = 16'hFFFF;
    localparam int          PRINT_LIMIT = 20;

    hmrc_pkg::t_cfg    regs;
    t_phase            phase;
    logic [15:0]       run_elapsed;
    logic [15:0]       overrun_left;
    logic [15:0]       lockout_left;
    logic [15:0]       since_button;
    logic [3:0]        diff_count;
    logic              hall_deb;
    logic              mag_cleared;

    hmrc_pkg::t_result pending_results[$];

    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == T_CEIL) ? v : v + 16'd1;
    endfunction

    // one millisecond tick of the controller: updates the mirrored state
    task automatic controller_tick(input hmrc_pkg::t_item it, output hmrc_pkg::t_result r);
        logic                  req;
        logic                  done;
        logic                  jam;
        logic                  stop;
        logic [15:0]           el;
        hmrc_pkg::t_req_status st;
        req  = it.run_request;
        done = 1'b0;
        jam  = 1'b0;
        stop = 1'b0;
        st   = hmrc_pkg::REQ_NONE;

        if (it.button_edge && since_button >= regs.button_guard_ticks) begin
            req          = 1'b1;
            since_button = 16'd1;
        end else begin
            since_button = sat_up(since_button);
        end

        if (phase == PH_IDLE && lockout_left != 16'd0)
            lockout_left = lockout_left - 16'd1;

        // a button edge and a software request together count as one request
        if (req) begin
            if (phase != PH_IDLE) begin
                st = hmrc_pkg::REQ_REFUSED_RUN;
            end else if (lockout_left != 16'd0) begin
                st = hmrc_pkg::REQ_REFUSED_LOCK;
            end else begin
                st          = hmrc_pkg::REQ_ACCEPTED;
                phase       = PH_RUN;
                run_elapsed = 16'd0;
                hall_deb    = it.hall_raw;
                diff_count  = 4'd0;
                mag_cleared = ~it.hall_raw;
            end
        end

        case (phase)
            PH_RUN: begin
                el = run_elapsed;
                // elapsed at the ceiling always ends the run
                if (el > regs.safety_ticks || el == T_CEIL) begin
                    jam  = 1'b1;
                    stop = 1'b1;
                end else begin
                    if (it.hall_raw == hall_deb) begin
                        diff_count = 4'd0;
                    end else begin
                        if (diff_count != 4'hF)
                            diff_count = diff_count + 4'd1;
                        if (diff_count >= regs.debounce_samples) begin
                            hall_deb   = it.hall_raw;
                            diff_count = 4'd0;
                        end
                    end
                    if (!hall_deb) begin
                        mag_cleared = 1'b1;
                    end else if (el >= regs.blanking_ticks && mag_cleared) begin
                        if (regs.overrun_ticks == 16'd0) begin
                            done = 1'b1;
                            stop = 1'b1;
                        end else begin
                            phase        = PH_OVERRUN;
                            overrun_left = regs.overrun_ticks;
                        end
                    end
                    run_elapsed = sat_up(el);
                end
            end
            PH_OVERRUN: begin
                if (overrun_left != 16'd0)
                    overrun_left = overrun_left - 16'd1;
                if (overrun_left == 16'd0) begin
                    done = 1'b1;
                    stop = 1'b1;
                end
            end
            default: ;
        endcase

        if (stop) begin
            phase        = PH_IDLE;
            overrun_left = 16'd0;
            lockout_left = regs.lockout_ticks;
        end

        r.motor_on       = (phase != PH_IDLE);
        r.run_done       = done;
        r.run_jammed     = jam;
        r.request_status = st;
        r.hall_level     = hall_deb;
    endtask

    task automatic check_bits(input string name, input logic [1:0] want, input logic [1:0] got);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        hmrc_pkg::t_result want;
        if (!i_rst_n) begin
            regs.debounce_samples   = hmrc_pkg::RST_DEBOUNCE;
            regs.blanking_ticks     = hmrc_pkg::RST_BLANKING;
            regs.overrun_ticks      = hmrc_pkg::RST_OVERRUN;
            regs.safety_ticks       = hmrc_pkg::RST_SAFETY;
            regs.lockout_ticks      = hmrc_pkg::RST_LOCKOUT;
            regs.button_guard_ticks = hmrc_pkg::RST_GUARD;
            phase        = PH_IDLE;
            run_elapsed  = 16'd0;
            overrun_left = 16'd0;
            lockout_left = 16'd0;
            since_button = 16'd0;
            diff_count   = 4'd0;
            hall_deb     = 1'b0;
            mag_cleared  = 1'b0;
            pending_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= PRINT_LIMIT)
                        $display("%0t: result transaction with nothing expected, got %h",
                                 $time, i_res_data);
                end else begin
                    want = pending_results.pop_front();
                    check_bits("motor_on", want.motor_on, i_res_data.motor_on);
                    check_bits("run_done", want.run_done, i_res_data.run_done);
                    check_bits("run_jammed", want.run_jammed, i_res_data.run_jammed);
                    check_bits("request_status", want.request_status,
                               i_res_data.request_status);
                    check_bits("hall_level", want.hall_level, i_res_data.hall_level);
                    o_checked++;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hmrc_pkg::CFG_DEBOUNCE:
                        regs.debounce_samples = i_cfg_data[hmrc_pkg::DEB_W-1:0];
                    hmrc_pkg::CFG_BLANKING: regs.blanking_ticks     = i_cfg_data;
                    hmrc_pkg::CFG_OVERRUN:  regs.overrun_ticks      = i_cfg_data;
                    hmrc_pkg::CFG_SAFETY:   regs.safety_ticks       = i_cfg_data;
                    hmrc_pkg::CFG_LOCKOUT:  regs.lockout_ticks      = i_cfg_data;
                    hmrc_pkg::CFG_GUARD:    regs.button_guard_ticks = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_tick_valid && i_tick_ready) begin
                controller_tick(i_tick_data, want);
                pending_results.push_back(want);
                if (want.run_done)
                    o_homed++;
                if (want.run_jammed)
                    o_jammed++;
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

// File: test/tb_homing_motor_run_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_homing_motor_run_controller: testbench of the homing motor run controller
// Drives tick transactions under several register settings and idling mixes,
// while a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_homing_motor_run_controller;

    localparam int IDLE_LIMIT       = 1000;
    localparam int RANDOM_PHASES    = 8;
    localparam int RANDOM_PER_PHASE = 92;
    localparam int DATA_W           = hmrc_pkg::CFG_DATA_W;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             cfg_we   = 1'b0;
    logic [hmrc_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [hmrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    hmrc_stream_if #(.T(hmrc_pkg::t_item))   tick_ch ();
    hmrc_stream_if #(.T(hmrc_pkg::t_result)) res_ch ();

    int fail_count;
    int outstanding;
    int checked;
    int homed;
    int jammed;

    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   hold_req       = 0;
    int   hold_left      = 0;
    logic hold_taken     = 1'b0;
    int   ticks_sent     = 0;
    int   cfg_sets       = 0;
    int   quiet_cycles   = 0;
    logic hall_now       = 1'b0;
    int   seg_left       = 0;

    homing_motor_run_controller #(
        .TIME_BITS (16)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_tick     (tick_ch),
        .o_result   (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hmrc_run_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_tick_valid  (tick_ch.valid),
        .i_tick_ready  (tick_ch.ready),
        .i_tick_data   (tick_ch.data),
        .i_res_valid   (res_ch.valid),
        .i_res_ready   (res_ch.ready),
        .i_res_data    (res_ch.data),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_homed       (homed),
        .o_jammed      (jammed)
    );

    always #6 clk = ~clk;

    // result side: random stalls, or a long hold-off when one is requested
    always @(negedge clk) begin
        if (hold_req != 0 && !hold_taken) begin
            hold_left    <= hold_req;
            hold_taken   <= 1'b1;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic hmrc_pkg::t_item make_tick(input logic hall, input logic req,
                                                  input logic btn);
        hmrc_pkg::t_item v;
        v.hall_raw    = hall;
        v.run_request = req;
        v.button_edge = btn;
        return v;
    endfunction

    // called and returns at a falling edge; valid stays high for a following item
    task automatic push_tick(input hmrc_pkg::t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= it;
        do @(posedge clk); while (!tick_ch.ready);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [hmrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hmrc_pkg::CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic apply_config(input hmrc_pkg::t_cfg c);
        write_reg(hmrc_pkg::CFG_DEBOUNCE, DATA_W'(c.debounce_samples));
        write_reg(hmrc_pkg::CFG_BLANKING, c.blanking_ticks);
        write_reg(hmrc_pkg::CFG_OVERRUN, c.overrun_ticks);
        write_reg(hmrc_pkg::CFG_SAFETY, c.safety_ticks);
        write_reg(hmrc_pkg::CFG_LOCKOUT, c.lockout_ticks);
        write_reg(hmrc_pkg::CFG_GUARD, c.button_guard_ticks);
        cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    // sensor held in segments of home / clear, so that runs start, leave and
    // return home; long segments end runs on the safety timeout
    task automatic feed_random(input int n);
        logic raw;
        repeat (n) begin
            if (seg_left == 0) begin
                hall_now = ~hall_now;
                seg_left = ($urandom_range(9) == 0) ? $urandom_range(20, 90)
                                                    : $urandom_range(1, 18);
            end
            seg_left--;
            // occasional single-sample bounce
            raw = hall_now ^ ($urandom_range(11) == 0);
            push_tick(make_tick(raw, $urandom_range(99) < 7, $urandom_range(99) < 5));
        end
    endtask

    initial begin : stimulus
        hmrc_pkg::t_cfg cfg_now;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset values: a button edge right after reset falls inside the guard
        push_tick(make_tick(1'b1, 1'b0, 1'b1));
        push_tick(make_tick(1'b0, 1'b0, 1'b0));
        drain();

        cfg_now = '{debounce_samples: 4'd2, blanking_ticks: 16'd3, overrun_ticks: 16'd2,
                    safety_ticks: 16'd6, lockout_ticks: 16'd3, button_guard_ticks: 16'd4};
        apply_config(cfg_now);
        push_tick(make_tick(1'b1, 1'b0, 1'b0));
        // start at home, leave, refused request while running, return home
        push_tick(make_tick(1'b1, 1'b1, 1'b0));
        repeat (3) push_tick(make_tick(1'b0, 1'b0, 1'b0));
        push_tick(make_tick(1'b0, 1'b1, 1'b0));
        repeat (5) push_tick(make_tick(1'b1, 1'b0, 1'b0));
        // refused in lockout; a button edge starts a run, the next is guarded
        push_tick(make_tick(1'b0, 1'b1, 1'b0));
        push_tick(make_tick(1'b0, 1'b0, 1'b1));
        push_tick(make_tick(1'b0, 1'b0, 1'b1));
        repeat (3) push_tick(make_tick(1'b0, 1'b0, 1'b0));
        // both requests in one tick are refused while running; the run homes
        push_tick(make_tick(1'b1, 1'b1, 1'b1));
        repeat (8) push_tick(make_tick(1'b1, 1'b0, 1'b0));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            cfg_now.debounce_samples   = 4'($urandom_range(1, 4));
            cfg_now.blanking_ticks     = 16'($urandom_range(0, 12));
            cfg_now.overrun_ticks      = 16'($urandom_range(0, 8));
            cfg_now.safety_ticks       = 16'($urandom_range(1, 60));
            cfg_now.lockout_ticks      = 16'($urandom_range(0, 15));
            cfg_now.button_guard_ticks = 16'($urandom_range(0, 20));
            if (p == 2)
                cfg_now = '{debounce_samples: 4'd0, blanking_ticks: 16'd0,
                            overrun_ticks: 16'd0, safety_ticks: 16'd1,
                            lockout_ticks: 16'd0, button_guard_ticks: 16'd0};
            if (p == 5) begin
                cfg_now.debounce_samples = 4'd15;
                cfg_now.safety_ticks     = 16'd60;
                cfg_now.lockout_ticks    = 16'd1;
            end
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            apply_config(cfg_now);
            feed_random(RANDOM_PER_PHASE / 2);
            // long receiver hold-off in phase 0 as ticks come; full drain mid phase 1
            if (p == 0)
                hold_req <= 60;
            if (p == 1)
                drain();
            feed_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
            if (p == RANDOM_PHASES - 1)
                repeat (80) push_tick(make_tick(1'b0, 1'b0, 1'b0));
            drain();
        end
        repeat (8) @(negedge clk);

        $display("Covered %0d ticks under %0d register settings, %0d results compared;",
                 ticks_sent, cfg_sets, checked);
        $display("%0d runs homed, %0d jammed, with back-pressure, idling and drains.",
                 homed, jammed);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
src/hmrc_pkg.sv
src/hmrc_stream_if.sv
src/hmrc_cfg.sv
src/hmrc_core.sv
src/homing_motor_run_controller.sv
test/hmrc_run_checker.sv
test/tb_homing_motor_run_controller.sv
